// ----- hw/rtl/keyword_frequency_counter_unit_assert.svh -----
// Assertion macros shared by the keyword counter RTL.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef KEYWORD_FREQUENCY_COUNTER_UNIT_ASSERT_SVH
`define KEYWORD_FREQUENCY_COUNTER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define KFC_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define KFC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Invariant that must hold at every edge out of reset.
`define KFC_ASSERT_ALWAYS(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

// ----- hw/rtl/kfc_pkg.sv -----
// Shared constants, types and hash tables for the keyword counter.
// No dependencies.
package kfc_pkg;

	localparam int KEYWORDS  = 32;
	localparam int MAX_LEN   = 16;
	localparam int CHAR_W    = 8;
	localparam int CNT_W     = 16;
	localparam int HASH_MULT = 100;
	localparam int HASH_MOD  = 41;
	localparam int BKT_W     = 6;

	localparam int KEY_W = (KEYWORDS > 1) ? $clog2(KEYWORDS) : 1;
	localparam int POS_W = $clog2(MAX_LEN);
	localparam int LEN_W = $clog2(MAX_LEN + 1);

	typedef enum logic [2:0] {
		OP_LOAD  = 3'd0,
		OP_TEXT  = 3'd1,
		OP_END   = 3'd2,
		OP_CLEAR = 3'd3,
		OP_READ  = 3'd4
	} op_t;

	typedef logic [KEYWORDS-1:0][CHAR_W-1:0] kw_row_t;

	// write request into the keyword character store
	typedef struct packed {
		logic              en;
		logic [POS_W-1:0]  row;
		logic [KEY_W-1:0]  slot;
		logic [CHAR_W-1:0] data;
	} kw_wr_t;

	typedef logic [BKT_W-1:0] bkt_t;
	typedef bkt_t [2**CHAR_W-1:0] bkt_tbl_t;

	// table of (v * step) mod HASH_MOD, built by running residue
	function automatic bkt_tbl_t mk_bkt_tbl(input int step);
		bkt_tbl_t tbl;
		int r;
		r = 0;
		for (int v = 0; v < 2**CHAR_W; v++) begin
			tbl[v] = BKT_W'(r);
			r = r + step;
			if (r >= HASH_MOD) begin
				r = r - HASH_MOD;
			end
		end
		return tbl;
	endfunction

	localparam int FIRST_STEP = HASH_MULT % HASH_MOD;
	localparam int LAST_STEP  = 1 % HASH_MOD;
	localparam bkt_tbl_t FIRST_TBL = mk_bkt_tbl(FIRST_STEP);
	localparam bkt_tbl_t LAST_TBL  = mk_bkt_tbl(LAST_STEP);

	function automatic logic is_letter(input logic [CHAR_W-1:0] c);
		return (c inside {[8'd65:8'd90], [8'd97:8'd122]});
	endfunction

endpackage

// ----- hw/rtl/kfc_kwmem.sv -----
// Keyword character store: one row per character position, one byte per slot.
// Depends on kfc_pkg. Registered read with same-cycle write forwarding.
module kfc_kwmem import kfc_pkg::*; (
	input  logic             clk,
	input  kw_wr_t           wr,
	input  logic [POS_W-1:0] rd_row,
	output kw_row_t          rd_data
);

	kw_row_t           kw_mem [MAX_LEN];
	kw_row_t           rd_q;
	logic              fwd_en_q;
	logic [KEY_W-1:0]  fwd_slot_q;
	logic [CHAR_W-1:0] fwd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			kw_mem[wr.row][wr.slot] <= wr.data;
		end
		rd_q       <= kw_mem[rd_row];
		fwd_en_q   <= wr.en && (wr.row == rd_row);
		fwd_slot_q <= wr.slot;
		fwd_data_q <= wr.data;
	end

	// a write landing on the row being read shows up in the read data
	always_comb begin
		rd_data = rd_q;
		if (fwd_en_q) begin
			rd_data[fwd_slot_q] = fwd_data_q;
		end
	end

endmodule

// ----- hw/rtl/keyword_frequency_counter_unit.sv -----
// Keyword occurrence counter, top level. Uses kfc_pkg and kfc_kwmem.
// Each request passes the input register, then the result register, and yields
// exactly one result. Throughput: one request per cycle without result_stall.
// Throughput is set by the single compare/update pass from the input register
// to the result register; the char store row is fetched ahead of its use.
// Reset (arst_n low): lengths, counts and word state clear; char store does not.
module keyword_frequency_counter_unit import kfc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         text_valid,
	output logic         text_stall,
	input  logic [2:0]   op,
	input  logic [4:0]   key_index,
	input  logic [3:0]   char_pos,
	input  logic [7:0]   ch,
	output logic         result_valid,
	input  logic         result_stall,
	output logic         word_done,
	output logic         matched,
	output logic [4:0]   match_index,
	output logic [5:0]   bucket,
	output logic [15:0]  count
);

`include "keyword_frequency_counter_unit_assert.svh"

	// ---------------------------------------------------------------
	// Input register stage
	// ---------------------------------------------------------------
	logic              valid_s1;
	logic [2:0]        op_s1;
	logic [4:0]        key_index_s1;
	logic [3:0]        char_pos_s1;
	logic [CHAR_W-1:0] ch_s1;

	// Result register
	logic              res_valid_q;
	logic              res_word_done_q;
	logic              res_matched_q;
	logic [4:0]        res_match_index_q;
	logic [BKT_W-1:0]  res_bucket_q;
	logic [CNT_W-1:0]  res_count_q;

	// Keyword table and counters
	logic [LEN_W-1:0]  len_q [KEYWORDS];
	logic [CNT_W-1:0]  cnt_q [KEYWORDS];

	// Word-in-progress state
	logic [KEYWORDS-1:0] still_q, still_d;
	logic [LEN_W-1:0]    wlen_q, wlen_d;
	logic [CHAR_W-1:0]   first_q, first_d;
	logic [CHAR_W-1:0]   last_q, last_d;
	logic                too_long_q, too_long_d;

	// Control
	logic out_free;
	logic fire_s1;
	logic key_ok;
	logic pos_ok;
	logic take;      // text letter extends the word
	logic fin;       // word boundary reached
	logic len_we;
	logic cnt_clr;
	logic cnt_we;
	kw_wr_t  kw_wr;
	kw_row_t kw_row;

	logic [KEYWORDS-1:0] hit_vec;
	logic                any_hit;
	logic [KEY_W-1:0]    match_idx;
	logic [KEY_W-1:0]    cnt_idx;
	logic [CNT_W-1:0]    cnt_rd;
	logic [CNT_W-1:0]    cnt_inc;
	logic [BKT_W:0]      bkt_sum;
	logic [BKT_W-1:0]    bkt_val;

	// Result fields computed for the request in s1
	logic              o_word_done;
	logic              o_matched;
	logic [BKT_W-1:0]  o_bucket;
	logic [CNT_W-1:0]  o_count;

	// The result register can take a new result when empty or being drained.
	assign out_free   = !res_valid_q || !result_stall;
	assign fire_s1    = valid_s1 && out_free;
	assign text_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!text_stall) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			op_s1        <= op;
			key_index_s1 <= key_index;
			char_pos_s1  <= char_pos;
			ch_s1        <= ch;
		end
	end

	// ---------------------------------------------------------------
	// Request decode
	// ---------------------------------------------------------------
	assign key_ok = (int'(key_index_s1) < KEYWORDS);
	assign pos_ok = (int'(char_pos_s1) < MAX_LEN);

	always_comb begin
		take    = 1'b0;
		fin     = 1'b0;
		len_we  = 1'b0;
		cnt_clr = 1'b0;
		kw_wr   = '0;
		kw_wr.row  = POS_W'(char_pos_s1);
		kw_wr.slot = KEY_W'(key_index_s1);
		kw_wr.data = ch_s1;
		if (fire_s1) begin
			case (op_s1)
				OP_LOAD: begin
					if (key_ok && pos_ok) begin
						// zero byte terminates the keyword and fixes its length
						if (ch_s1 == '0) begin
							len_we = 1'b1;
						end else begin
							kw_wr.en = 1'b1;
						end
					end
				end
				OP_TEXT: begin
					if (is_letter(ch_s1)) begin
						take = 1'b1;
					end else begin
						fin = 1'b1;
					end
				end
				OP_END: begin
					fin = 1'b1;
				end
				OP_CLEAR: begin
					cnt_clr = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Keyword char store: row for the current word position is read ahead
	// through the registered read, addressed by the next word length.
	// ---------------------------------------------------------------
	kfc_kwmem u_kwmem (
		.clk     (clk),
		.wr      (kw_wr),
		.rd_row  (wlen_d[POS_W-1:0]),
		.rd_data (kw_row)
	);

	// ---------------------------------------------------------------
	// Word end: match vector, lowest hit, counter update
	// ---------------------------------------------------------------
	always_comb begin
		for (int k = 0; k < KEYWORDS; k++) begin
			hit_vec[k] = still_q[k] && (len_q[k] != '0) && (len_q[k] == wlen_q) &&
				!too_long_q;
		end
	end

	assign any_hit = |hit_vec;

	always_comb begin
		match_idx = '0;
		for (int k = KEYWORDS - 1; k >= 0; k--) begin
			if (hit_vec[k]) begin
				match_idx = KEY_W'(k);
			end
		end
	end

	// read-count and word-end never share a request, so one read port serves both
	assign cnt_idx = (op_s1 == OP_READ) ? KEY_W'(key_index_s1) : match_idx;
	assign cnt_rd  = cnt_q[cnt_idx];
	assign cnt_inc = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;

	// bucket = (first*100 + last) mod 41 from two residue tables
	assign bkt_sum = {1'b0, FIRST_TBL[first_q]} + {1'b0, LAST_TBL[last_q]};
	assign bkt_val = (bkt_sum >= (BKT_W+1)'(HASH_MOD)) ?
		BKT_W'(bkt_sum - (BKT_W+1)'(HASH_MOD)) : BKT_W'(bkt_sum);

	// ---------------------------------------------------------------
	// Next word state and result fields
	// ---------------------------------------------------------------
	always_comb begin
		still_d     = still_q;
		wlen_d      = wlen_q;
		first_d     = first_q;
		last_d      = last_q;
		too_long_d  = too_long_q;
		cnt_we      = 1'b0;
		o_word_done = 1'b0;
		o_matched   = 1'b0;
		o_bucket    = '0;
		o_count     = '0;

		if (take) begin
			if (wlen_q == '0) begin
				first_d = ch_s1;
			end
			last_d = ch_s1;
			if (int'(wlen_q) >= MAX_LEN) begin
				too_long_d = 1'b1;
			end else begin
				for (int k = 0; k < KEYWORDS; k++) begin
					if ((wlen_q >= len_q[k]) || (kw_row[k] != ch_s1)) begin
						still_d[k] = 1'b0;
					end
				end
				wlen_d = wlen_q + 1'b1;
			end
		end

		if (fin) begin
			if (wlen_q != '0) begin
				o_word_done = 1'b1;
				o_bucket    = bkt_val;
				if (any_hit) begin
					o_matched = 1'b1;
					o_count   = cnt_inc;
					cnt_we    = 1'b1;
				end
			end
			still_d    = '1;
			wlen_d     = '0;
			first_d    = '0;
			last_d     = '0;
			too_long_d = 1'b0;
		end

		if (fire_s1 && (op_s1 == OP_READ) && key_ok) begin
			o_count = cnt_rd;
		end
	end

	// ---------------------------------------------------------------
	// State registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			still_q    <= '1;
			wlen_q     <= '0;
			first_q    <= '0;
			last_q     <= '0;
			too_long_q <= 1'b0;
			for (int k = 0; k < KEYWORDS; k++) begin
				len_q[k] <= '0;
				cnt_q[k] <= '0;
			end
		end else begin
			still_q    <= still_d;
			wlen_q     <= wlen_d;
			first_q    <= first_d;
			last_q     <= last_d;
			too_long_q <= too_long_d;
			if (len_we) begin
				len_q[KEY_W'(key_index_s1)] <= LEN_W'(char_pos_s1);
			end
			if (cnt_clr) begin
				for (int k = 0; k < KEYWORDS; k++) begin
					cnt_q[k] <= '0;
				end
			end else if (cnt_we) begin
				cnt_q[match_idx] <= cnt_inc;
			end
		end
	end

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire_s1) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_word_done_q   <= o_word_done;
			res_matched_q     <= o_matched;
			res_match_index_q <= o_matched ? 5'(match_idx) : 5'd0;
			res_bucket_q      <= o_bucket;
			res_count_q       <= o_count;
		end
	end

	assign result_valid = res_valid_q;
	assign word_done    = res_word_done_q;
	assign matched      = res_matched_q;
	assign match_index  = res_match_index_q;
	assign bucket       = res_bucket_q;
	assign count        = res_count_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`KFC_ASSERT_NEXT(a_fire_gives_result, fire_s1, res_valid_q,
		"processed request did not produce a result")
	`KFC_ASSERT_NOW(a_match_needs_word, res_valid_q && res_matched_q, res_word_done_q,
		"match reported without a completed word")
	`KFC_ASSERT_NOW(a_bucket_range, res_valid_q, int'(res_bucket_q) < HASH_MOD,
		"bucket out of hash range")
	`KFC_ASSERT_ALWAYS(a_wlen_bound, int'(wlen_q) <= MAX_LEN,
		"word length past maximum")
	`KFC_ASSERT_NOW(a_too_long_len, too_long_q, int'(wlen_q) == MAX_LEN,
		"long-word flag set below maximum length")

endmodule
